@@ sv/lcdw_pkg.sv @@
// Shared types, codes and constants for the character LCD 4-bit write sequencer.
`timescale 1ns / 1ps
package lcdw_pkg;

  localparam int unsigned TICK_W = 16;
  localparam int unsigned HOLD_W = 17;
  localparam int unsigned PC_W   = 6;

  localparam logic [2:0] FUNC_INSTR  = 3'd0;
  localparam logic [2:0] FUNC_DATA   = 3'd1;
  localparam logic [2:0] FUNC_CLEAR  = 3'd2;
  localparam logic [2:0] FUNC_HOME   = 3'd3;
  localparam logic [2:0] FUNC_CURSOR = 3'd4;
  localparam logic [2:0] FUNC_INIT   = 3'd5;

  localparam logic [2:0] CFG_ENABLE_PULSE = 3'd0;
  localparam logic [2:0] CFG_BYTE_SETTLE  = 3'd1;
  localparam logic [2:0] CFG_CLEAR_WAIT   = 3'd2;
  localparam logic [2:0] CFG_POWER_WAIT   = 3'd3;
  localparam logic [2:0] CFG_WAKE_WAIT    = 3'd4;

  localparam logic [TICK_W-1:0] RST_ENABLE_PULSE = 16'd1;
  localparam logic [TICK_W-1:0] RST_BYTE_SETTLE  = 16'd25;
  localparam logic [TICK_W-1:0] RST_CLEAR_WAIT   = 16'd500;
  localparam logic [TICK_W-1:0] RST_POWER_WAIT   = 16'd12500;
  localparam logic [TICK_W-1:0] RST_WAKE_WAIT    = 16'd1125;

  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME  = 8'h02;

  localparam logic [PC_W-1:0] ADDR_BYTE         = 6'd0;
  localparam logic [PC_W-1:0] ADDR_BYTE_CLR_END = 6'd6;
  localparam logic [PC_W-1:0] ADDR_INIT         = 6'd7;
  localparam logic [PC_W-1:0] ADDR_LAST         = 6'd43;

  typedef enum logic [1:0] {
    NIB_HI    = 2'd0,
    NIB_LO    = 2'd1,
    NIB_CONST = 2'd2
  } nib_src_t;

  typedef enum logic [2:0] {
    HOLD_ZERO       = 3'd0,
    HOLD_PULSE      = 3'd1,
    HOLD_SETTLE     = 3'd2,
    HOLD_SETTLE_CLR = 3'd3,
    HOLD_POWER      = 3'd4,
    HOLD_WAKE       = 3'd5
  } hold_sel_t;

  typedef enum logic {
    JMP_NEXT   = 1'b0,
    JMP_IF_CLR = 1'b1
  } jmp_t;

  typedef struct packed {
    logic             en;
    nib_src_t         nib_src;
    logic [3:0]       const_nib;
    hold_sel_t        hold_sel;
    logic             last;
    jmp_t             jmp;
    logic [PC_W-1:0]  target;
  } ucw_t;

  typedef struct packed {
    logic [TICK_W-1:0] enable_pulse_ticks;
    logic [TICK_W-1:0] byte_settle_ticks;
    logic [TICK_W-1:0] clear_wait_ticks;
    logic [TICK_W-1:0] power_wait_ticks;
    logic [TICK_W-1:0] wake_wait_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] byte_value;
    logic [5:0] column;
    logic       row;
  } in_item_t;

  typedef struct packed {
    logic              reg_select;
    logic              enable;
    logic [3:0]        nibble;
    logic [HOLD_W-1:0] hold_ticks;
    logic              last;
  } out_item_t;

endpackage

@@ sv/lcdw_ucode_rom.sv @@
// Microcode ROM: one control word per pin-state step.
`timescale 1ns / 1ps
module lcdw_ucode_rom (
  input  logic [lcdw_pkg::PC_W-1:0] addr,
  output lcdw_pkg::ucw_t            word
);
  import lcdw_pkg::*;

  function automatic ucw_t mk(input logic en, input nib_src_t src, input logic [3:0] nib,
                              input hold_sel_t hold, input logic last);
    ucw_t w;
    w.en        = en;
    w.nib_src   = src;
    w.const_nib = nib;
    w.hold_sel  = hold;
    w.last      = last;
    w.jmp       = JMP_NEXT;
    w.target    = ADDR_BYTE;
    return w;
  endfunction

  always_comb begin
    unique case (addr)
      // byte write from operand register
      6'd0:  word = mk(1'b0, NIB_HI, 4'h0, HOLD_ZERO, 1'b0);
      6'd1:  word = mk(1'b1, NIB_HI, 4'h0, HOLD_PULSE, 1'b0);
      6'd2:  word = mk(1'b0, NIB_HI, 4'h0, HOLD_ZERO, 1'b0);
      6'd3:  word = mk(1'b0, NIB_LO, 4'h0, HOLD_ZERO, 1'b0);
      6'd4: begin
        word        = mk(1'b1, NIB_LO, 4'h0, HOLD_PULSE, 1'b0);
        word.jmp    = JMP_IF_CLR;
        word.target = ADDR_BYTE_CLR_END;
      end
      6'd5:  word = mk(1'b0, NIB_LO, 4'h0, HOLD_SETTLE, 1'b1);
      6'd6:  word = mk(1'b0, NIB_LO, 4'h0, HOLD_SETTLE_CLR, 1'b1);
      // init: power wait
      6'd7:  word = mk(1'b0, NIB_CONST, 4'h0, HOLD_POWER, 1'b0);
      // wake nibbles
      6'd8:  word = mk(1'b0, NIB_CONST, 4'h3, HOLD_ZERO, 1'b0);
      6'd9:  word = mk(1'b1, NIB_CONST, 4'h3, HOLD_PULSE, 1'b0);
      6'd10: word = mk(1'b0, NIB_CONST, 4'h3, HOLD_WAKE, 1'b0);
      6'd11: word = mk(1'b0, NIB_CONST, 4'h3, HOLD_ZERO, 1'b0);
      6'd12: word = mk(1'b1, NIB_CONST, 4'h3, HOLD_PULSE, 1'b0);
      6'd13: word = mk(1'b0, NIB_CONST, 4'h3, HOLD_WAKE, 1'b0);
      6'd14: word = mk(1'b0, NIB_CONST, 4'h3, HOLD_ZERO, 1'b0);
      6'd15: word = mk(1'b1, NIB_CONST, 4'h3, HOLD_PULSE, 1'b0);
      6'd16: word = mk(1'b0, NIB_CONST, 4'h3, HOLD_WAKE, 1'b0);
      // switch to 4-bit
      6'd17: word = mk(1'b0, NIB_CONST, 4'h2, HOLD_ZERO, 1'b0);
      6'd18: word = mk(1'b1, NIB_CONST, 4'h2, HOLD_PULSE, 1'b0);
      6'd19: word = mk(1'b0, NIB_CONST, 4'h2, HOLD_ZERO, 1'b0);
      // function set 0x28
      6'd20: word = mk(1'b0, NIB_CONST, 4'h2, HOLD_ZERO, 1'b0);
      6'd21: word = mk(1'b1, NIB_CONST, 4'h2, HOLD_PULSE, 1'b0);
      6'd22: word = mk(1'b0, NIB_CONST, 4'h2, HOLD_ZERO, 1'b0);
      6'd23: word = mk(1'b0, NIB_CONST, 4'h8, HOLD_ZERO, 1'b0);
      6'd24: word = mk(1'b1, NIB_CONST, 4'h8, HOLD_PULSE, 1'b0);
      6'd25: word = mk(1'b0, NIB_CONST, 4'h8, HOLD_SETTLE, 1'b0);
      // entry mode 0x06
      6'd26: word = mk(1'b0, NIB_CONST, 4'h0, HOLD_ZERO, 1'b0);
      6'd27: word = mk(1'b1, NIB_CONST, 4'h0, HOLD_PULSE, 1'b0);
      6'd28: word = mk(1'b0, NIB_CONST, 4'h0, HOLD_ZERO, 1'b0);
      6'd29: word = mk(1'b0, NIB_CONST, 4'h6, HOLD_ZERO, 1'b0);
      6'd30: word = mk(1'b1, NIB_CONST, 4'h6, HOLD_PULSE, 1'b0);
      6'd31: word = mk(1'b0, NIB_CONST, 4'h6, HOLD_SETTLE, 1'b0);
      // display on 0x0C
      6'd32: word = mk(1'b0, NIB_CONST, 4'h0, HOLD_ZERO, 1'b0);
      6'd33: word = mk(1'b1, NIB_CONST, 4'h0, HOLD_PULSE, 1'b0);
      6'd34: word = mk(1'b0, NIB_CONST, 4'h0, HOLD_ZERO, 1'b0);
      6'd35: word = mk(1'b0, NIB_CONST, 4'hC, HOLD_ZERO, 1'b0);
      6'd36: word = mk(1'b1, NIB_CONST, 4'hC, HOLD_PULSE, 1'b0);
      6'd37: word = mk(1'b0, NIB_CONST, 4'hC, HOLD_SETTLE, 1'b0);
      // clear 0x01
      6'd38: word = mk(1'b0, NIB_CONST, 4'h0, HOLD_ZERO, 1'b0);
      6'd39: word = mk(1'b1, NIB_CONST, 4'h0, HOLD_PULSE, 1'b0);
      6'd40: word = mk(1'b0, NIB_CONST, 4'h0, HOLD_ZERO, 1'b0);
      6'd41: word = mk(1'b0, NIB_CONST, 4'h1, HOLD_ZERO, 1'b0);
      6'd42: word = mk(1'b1, NIB_CONST, 4'h1, HOLD_PULSE, 1'b0);
      6'd43: word = mk(1'b0, NIB_CONST, 4'h1, HOLD_SETTLE_CLR, 1'b1);
      default: word = mk(1'b0, NIB_CONST, 4'h0, HOLD_ZERO, 1'b1);
    endcase
  end

endmodule

@@ sv/lcdw_datapath.sv @@
// Pin-state datapath: nibble and hold selection under control of a microcode word.
`timescale 1ns / 1ps
module lcdw_datapath (
  input  lcdw_pkg::ucw_t      ucw,
  input  logic [7:0]          oper_byte,
  input  logic                oper_rs,
  input  lcdw_pkg::cfg_regs_t cfg,
  output lcdw_pkg::out_item_t item
);
  import lcdw_pkg::*;

  logic [3:0]        nib;
  logic [HOLD_W-1:0] hold;

  always_comb begin
    unique case (ucw.nib_src)
      NIB_HI:    nib = oper_byte[7:4];
      NIB_LO:    nib = oper_byte[3:0];
      NIB_CONST: nib = ucw.const_nib;
      default:   nib = ucw.const_nib;
    endcase
  end

  always_comb begin
    unique case (ucw.hold_sel)
      HOLD_ZERO:       hold = '0;
      HOLD_PULSE:      hold = {1'b0, cfg.enable_pulse_ticks};
      HOLD_SETTLE:     hold = {1'b0, cfg.byte_settle_ticks};
      HOLD_SETTLE_CLR: hold = {1'b0, cfg.byte_settle_ticks} + {1'b0, cfg.clear_wait_ticks};
      HOLD_POWER:      hold = {1'b0, cfg.power_wait_ticks};
      HOLD_WAKE:       hold = {1'b0, cfg.wake_wait_ticks};
      default:         hold = '0;
    endcase
  end

  always_comb begin
    item.reg_select = (ucw.nib_src == NIB_CONST) ? 1'b0 : oper_rs;
    item.enable     = ucw.en;
    item.nibble     = nib;
    item.hold_ticks = hold;
    item.last       = ucw.last;
  end

endmodule

@@ sv/char_lcd_4bit_write_sequencer_top.sv @@
// Top level: request intake, step counter, configuration registers and result register.
// A request is registered first; the first pin state is then registered into out_data.
// Throughput: one pin state per cycle while out_ready is high; a byte operation
// produces 6 pin states and init 37 pin states, as laid out in the microcode ROM.
// Function codes 6 and 7 are taken and produce no pin states.
// Reset (synchronous, active low) idles the step counter, drops out_valid,
// loads register defaults.
`timescale 1ns / 1ps
module char_lcd_4bit_write_sequencer_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lcdw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lcdw_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import lcdw_pkg::*;

  cfg_regs_t       cfg_r;
  logic            busy_r;
  logic [PC_W-1:0] pc_r;
  logic [7:0]      oper_byte_r;
  logic            oper_rs_r;
  logic            clr_r;
  logic            out_valid_r;
  out_item_t       out_data_r;

  ucw_t      ucw;
  out_item_t item;
  logic      accept;
  logic      issue;
  logic      func_ok;
  logic [7:0] oper_byte_nxt;

  lcdw_ucode_rom u_rom (
    .addr (pc_r),
    .word (ucw)
  );

  lcdw_datapath u_dp (
    .ucw       (ucw),
    .oper_byte (oper_byte_r),
    .oper_rs   (oper_rs_r),
    .cfg       (cfg_r),
    .item      (item)
  );

  assign in_ready  = !busy_r;
  assign accept    = in_valid && in_ready;
  assign issue     = busy_r && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign func_ok   = (in_data.func <= FUNC_INIT);

  always_comb begin
    unique case (in_data.func)
      FUNC_CLEAR:  oper_byte_nxt = CMD_CLEAR;
      FUNC_HOME:   oper_byte_nxt = CMD_HOME;
      FUNC_CURSOR: oper_byte_nxt = {1'b1, in_data.row, in_data.column};
      default:     oper_byte_nxt = in_data.byte_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_pulse_ticks <= RST_ENABLE_PULSE;
      cfg_r.byte_settle_ticks  <= RST_BYTE_SETTLE;
      cfg_r.clear_wait_ticks   <= RST_CLEAR_WAIT;
      cfg_r.power_wait_ticks   <= RST_POWER_WAIT;
      cfg_r.wake_wait_ticks    <= RST_WAKE_WAIT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ENABLE_PULSE: cfg_r.enable_pulse_ticks <= cfg_wdata;
        CFG_BYTE_SETTLE:  cfg_r.byte_settle_ticks  <= cfg_wdata;
        CFG_CLEAR_WAIT:   cfg_r.clear_wait_ticks   <= cfg_wdata;
        CFG_POWER_WAIT:   cfg_r.power_wait_ticks   <= cfg_wdata;
        CFG_WAKE_WAIT:    cfg_r.wake_wait_ticks    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= ADDR_BYTE;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= func_ok;
        pc_r   <= (in_data.func == FUNC_INIT) ? ADDR_INIT : ADDR_BYTE;
      end else if (issue) begin
        if (ucw.last) begin
          busy_r <= 1'b0;
        end else if (ucw.jmp == JMP_IF_CLR && clr_r) begin
          pc_r <= ucw.target;
        end else begin
          pc_r <= pc_r + PC_W'(1);
        end
      end
      if (issue) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      oper_byte_r <= oper_byte_nxt;
      oper_rs_r   <= (in_data.func == FUNC_DATA);
      clr_r       <= (in_data.func == FUNC_CLEAR) || (in_data.func == FUNC_HOME);
    end
    if (issue) begin
      out_data_r <= item;
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && func_ok |=> busy_r)
    else $error("valid request did not start the sequencer");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pc_r <= ADDR_LAST)
    else $error("step counter outside the microcode program");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    issue && ucw.last |=> !busy_r && out_valid_r && out_data_r.last)
    else $error("final step did not end the run");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))
    else $error("pin state changed while waiting for transfer");

endmodule

@@ dv/char_lcd_4bit_write_sequencer_top_tb.sv @@
// Testbench for the 4-bit LCD write sequencer: random requests, pin-state prediction, checks.
`timescale 1ns / 1ps
module char_lcd_4bit_write_sequencer_top_tb;
  import lcdw_pkg::*;

  localparam logic [2:0] FUNC_RSVD_A = 3'd6;
  localparam logic [2:0] FUNC_RSVD_B = 3'd7;
  localparam logic [2:0] CFG_RSVD_A  = 3'd5;
  localparam logic [2:0] CFG_RSVD_B  = 3'd7;

  localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
  localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
  localparam logic [6:0] ROW1_OFFSET    = 7'h40;
  localparam logic [3:0] NIB_WAKE       = 4'h3;
  localparam logic [3:0] NIB_4BIT       = 4'h2;
  localparam logic       RS_INSTR       = 1'b0;
  localparam logic       RS_DATA        = 1'b1;

  localparam int MAX_IDLE      = 6;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = CFG_ENABLE_PULSE;
  logic [15:0] cfg_wdata = '0;

  cfg_regs_t   tick_regs;
  in_item_t    req_q[$];
  out_item_t   pin_states_due[$];
  int          gap_left = 0;
  int          stall_left = 0;
  int          long_holds_wanted = 0;
  int          long_holds_done = 0;
  int          mismatches = 0;
  int          cycles = 0;
  bit          no_idle = 1'b0;

  char_lcd_4bit_write_sequencer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_pin(logic rs, logic en, logic [3:0] nib,
                                   logic [HOLD_W-1:0] hold);
    out_item_t p;
    p.reg_select = rs;
    p.enable     = en;
    p.nibble     = nib;
    p.hold_ticks = hold;
    p.last       = 1'b0;
    pin_states_due.push_back(p);
  endfunction

  function automatic void push_nibble(logic rs, logic [3:0] nib, logic [HOLD_W-1:0] after);
    push_pin(rs, 1'b0, nib, '0);
    push_pin(rs, 1'b1, nib, {1'b0, tick_regs.enable_pulse_ticks});
    push_pin(rs, 1'b0, nib, after);
  endfunction

  function automatic void push_byte(logic rs, logic [7:0] value, logic [TICK_W-1:0] extra);
    push_nibble(rs, value[7:4], '0);
    push_nibble(rs, value[3:0], {1'b0, tick_regs.byte_settle_ticks} + {1'b0, extra});
  endfunction

  function automatic void lcd_pin_run(in_item_t req);
    int         first;
    logic [6:0] ddram_addr;
    first      = pin_states_due.size();
    ddram_addr = {1'b0, req.column} + (req.row ? ROW1_OFFSET : 7'h00);
    case (req.func)
      FUNC_INSTR:  push_byte(RS_INSTR, req.byte_value, '0);
      FUNC_DATA:   push_byte(RS_DATA, req.byte_value, '0);
      FUNC_CLEAR:  push_byte(RS_INSTR, CMD_CLEAR, tick_regs.clear_wait_ticks);
      FUNC_HOME:   push_byte(RS_INSTR, CMD_HOME, tick_regs.clear_wait_ticks);
      FUNC_CURSOR: push_byte(RS_INSTR, CMD_SET_DDRAM | {1'b0, ddram_addr}, '0);
      FUNC_INIT: begin
        push_pin(RS_INSTR, 1'b0, 4'h0, {1'b0, tick_regs.power_wait_ticks});
        repeat (3) push_nibble(RS_INSTR, NIB_WAKE, {1'b0, tick_regs.wake_wait_ticks});
        push_nibble(RS_INSTR, NIB_4BIT, '0);
        push_byte(RS_INSTR, CMD_FUNC_SET, '0);
        push_byte(RS_INSTR, CMD_ENTRY_MODE, '0);
        push_byte(RS_INSTR, CMD_DISP_ON, '0);
        push_byte(RS_INSTR, CMD_CLEAR, tick_regs.clear_wait_ticks);
      end
      default: ;
    endcase
    if (pin_states_due.size() > first)
      pin_states_due[pin_states_due.size() - 1].last = 1'b1;
  endfunction

  function automatic int draw_idle();
    return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready)
        lcd_pin_run(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (req_q.size() != 0) begin
          in_data  <= req_q.pop_front();
          in_valid <= 1'b1;
          gap_left <= draw_idle();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // pin-state monitor
  always @(posedge clk) begin
    out_item_t exp_pin;
    int        nd;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pin_states_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected pin state: rs=%0b en=%0b nib=%h hold=%0d last=%0b",
                     out_data.reg_select, out_data.enable, out_data.nibble,
                     out_data.hold_ticks, out_data.last);
          mismatches++;
        end else begin
          exp_pin = pin_states_due.pop_front();
          if (out_data !== exp_pin) begin
            if (mismatches < 10)
              $display("mismatch: exp %0b %0b %h %0d %0b | got %0b %0b %h %0d %0b",
                       exp_pin.reg_select, exp_pin.enable, exp_pin.nibble,
                       exp_pin.hold_ticks, exp_pin.last,
                       out_data.reg_select, out_data.enable, out_data.nibble,
                       out_data.hold_ticks, out_data.last);
            mismatches++;
          end
        end
      end
      if (long_holds_done != long_holds_wanted) begin
        out_ready       <= 1'b0;
        stall_left      <= LONG_HOLD;
        long_holds_done <= long_holds_done + 1;
      end else if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (out_valid && out_ready) begin
        nd = draw_idle();
        if (nd == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready  <= 1'b0;
          stall_left <= nd - 1;
        end
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_req(logic [2:0] func, logic [7:0] value, logic [5:0] col, logic row);
    in_item_t r;
    r.func       = func;
    r.byte_value = value;
    r.column     = col;
    r.row        = row;
    req_q.push_back(r);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (req_q.size() != 0 || in_valid || pin_states_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_ENABLE_PULSE: tick_regs.enable_pulse_ticks = value;
      CFG_BYTE_SETTLE:  tick_regs.byte_settle_ticks  = value;
      CFG_CLEAR_WAIT:   tick_regs.clear_wait_ticks   = value;
      CFG_POWER_WAIT:   tick_regs.power_wait_ticks   = value;
      CFG_WAKE_WAIT:    tick_regs.wake_wait_ticks    = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_regs(logic [15:0] pulse, logic [15:0] settle, logic [15:0] clr,
                           logic [15:0] power, logic [15:0] wake);
    write_reg(CFG_ENABLE_PULSE, pulse);
    write_reg(CFG_BYTE_SETTLE, settle);
    write_reg(CFG_CLEAR_WAIT, clr);
    write_reg(CFG_POWER_WAIT, power);
    write_reg(CFG_WAKE_WAIT, wake);
  endtask

  function automatic logic [15:0] pick_ticks();
    case ($urandom_range(0, 2))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [2:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return FUNC_INSTR;
    if (r < 55) return FUNC_DATA;
    if (r < 63) return FUNC_CLEAR;
    if (r < 70) return FUNC_HOME;
    if (r < 85) return FUNC_CURSOR;
    if (r < 95) return FUNC_INIT;
    return (r[0]) ? FUNC_RSVD_B : FUNC_RSVD_A;
  endfunction

  task automatic run_phase(int n_items, bit idle_off, bit long_hold);
    @(negedge clk);
    no_idle = idle_off;
    if (long_hold)
      long_holds_wanted++;
    repeat (n_items)
      queue_req(pick_func(), 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                1'($urandom_range(0, 1)));
    wait_drained();
  endtask

  initial begin
    tick_regs.enable_pulse_ticks = RST_ENABLE_PULSE;
    tick_regs.byte_settle_ticks  = RST_BYTE_SETTLE;
    tick_regs.clear_wait_ticks   = RST_CLEAR_WAIT;
    tick_regs.power_wait_ticks   = RST_POWER_WAIT;
    tick_regs.wake_wait_ticks    = RST_WAKE_WAIT;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    queue_req(FUNC_INSTR, 8'h00, 6'd0, 1'b0);
    queue_req(FUNC_INSTR, 8'hFF, 6'd63, 1'b1);
    queue_req(FUNC_DATA, 8'h00, 6'd0, 1'b0);
    queue_req(FUNC_DATA, 8'hFF, 6'd0, 1'b0);
    queue_req(FUNC_DATA, 8'hA5, 6'd21, 1'b1);
    queue_req(FUNC_DATA, 8'h5A, 6'd42, 1'b0);
    queue_req(FUNC_CLEAR, 8'h00, 6'd0, 1'b0);
    queue_req(FUNC_HOME, 8'hFF, 6'd63, 1'b1);
    queue_req(FUNC_CURSOR, 8'h00, 6'd0, 1'b0);
    queue_req(FUNC_CURSOR, 8'hFF, 6'd63, 1'b0);
    queue_req(FUNC_CURSOR, 8'h00, 6'd0, 1'b1);
    queue_req(FUNC_CURSOR, 8'hFF, 6'd63, 1'b1);
    queue_req(FUNC_INIT, 8'h00, 6'd0, 1'b0);
    queue_req(FUNC_RSVD_A, 8'hFF, 6'd63, 1'b1);
    queue_req(FUNC_DATA, 8'h41, 6'd5, 1'b0);
    queue_req(FUNC_RSVD_B, 8'h00, 6'd0, 1'b0);
    queue_req(FUNC_RSVD_B, 8'hFF, 6'd63, 1'b1);
    queue_req(FUNC_INIT, 8'hFF, 6'd63, 1'b1);
    queue_req(FUNC_INSTR, 8'h80, 6'd1, 1'b0);
    queue_req(FUNC_RSVD_A, 8'h00, 6'd0, 1'b0);
    wait_drained();

    // unmapped indexes must not disturb the tick registers
    write_reg(CFG_RSVD_A, 16'hFFFF);
    write_reg(CFG_RSVD_B, 16'h0000);
    run_phase(30, 1'b0, 1'b0);

    load_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_phase(40, 1'b0, 1'b0);

    load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(40, 1'b1, 1'b1);

    for (int k = 0; k < 3; k++) begin
      load_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)));
      run_phase(40, k == 2, k == 1);
    end

    load_regs(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
    run_phase(45, 1'b0, 1'b0);

    if (mismatches == 0 && pin_states_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
